FILE: src/trace_stream_deframer_checker_core_assert.svh
// Assertion macros shared by the trace stream deframer and checker modules.
`ifndef TRACE_STREAM_DEFRAMER_CHECKER_CORE_ASSERT_SVH
`define TRACE_STREAM_DEFRAMER_CHECKER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define TSDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsdc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsdc assertion failed");

`else

`define TSDC_ASSERT_IMP(lbl, ante, cons)
`define TSDC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/tsdc_pkg.sv
// Types and constants of the trace stream deframer and checker.
package tsdc_pkg;

    localparam int TSDC_QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // Register indexes (byte address / 8)
    localparam logic [1:0] CFG_IDX_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_IDX_MAJOR       = 2'd1;
    localparam logic [1:0] CFG_IDX_MINOR       = 2'd2;

    localparam logic [34:0] CFG_MAX_PAYLOAD_RST = 35'h4_0000_0000;
    localparam logic [15:0] CFG_MAJOR_RST       = 16'd1;
    localparam logic [15:0] CFG_MINOR_RST       = 16'd0;

    // Result kinds
    localparam logic [1:0] OUT_REC_HDR = 2'd0;
    localparam logic [1:0] OUT_PAYLOAD = 2'd1;
    localparam logic [1:0] OUT_ERROR   = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_MAGIC     = 4'd0;
    localparam logic [3:0] ERR_MAJOR     = 4'd1;
    localparam logic [3:0] ERR_MINOR     = 4'd2;
    localparam logic [3:0] ERR_ENDIAN    = 4'd3;
    localparam logic [3:0] ERR_HDR_SIZE  = 4'd4;
    localparam logic [3:0] ERR_SEQUENCE  = 4'd5;
    localparam logic [3:0] ERR_ZERO_KIND = 4'd6;
    localparam logic [3:0] ERR_SIZE      = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED = 4'd8;

    // "RTDBGTRC" read little-endian
    localparam logic [63:0] STREAM_MAGIC = 64'h4352_5447_4244_5452;
    localparam logic [31:0] ENDIAN_MARK  = 32'h0102_0304;
    localparam logic [63:0] HEADER_BYTES = 64'd24;
    localparam logic [4:0]  HDR_LAST_IDX = 5'd23;
    localparam logic [4:0]  MAGIC_LAST_IDX = 5'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } src_item_t;

    typedef struct packed {
        logic [1:0]  out_type;
        logic [63:0] rec_sequence;
        logic [31:0] rec_kind;
        logic [31:0] rec_flags;
        logic [34:0] rec_size;
        logic [7:0]  payload_value;
        logic        last;
        logic [3:0]  error_code;
    } res_item_t;

    typedef struct packed {
        logic [34:0] max_payload_bytes;
        logic [15:0] supported_major;
        logic [15:0] supported_minor;
    } cfg_t;

endpackage

FILE: src/trace_stream_deframer_checker_core.sv
// Trace stream deframer and checker: one stream byte per cycle in while src_stall is
// low, at most one result item per byte out. The parser takes a byte in every cycle
// in which the result queue has room and finishes its header and record checks in
// that same cycle; one parser state step per accepted byte sets the rate of one
// item per cycle. Results are registered and wait in a QUEUE_DEPTH-entry queue
// (two by default); src_stall rises only while the queue is full. The first error is
// reported once, and an end of stream at a record boundary finishes quietly; after
// either the block drops every item until reset. Registers sit at byte addresses
// 0 (max_payload_bytes), 8 (supported_major) and 16 (supported_minor) and should be
// written only while the block is idle.
module trace_stream_deframer_checker_core
    import tsdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = TSDC_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  src_item_t             src_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res_item
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;
    logic       full;
    logic       push;
    res_item_t  push_item;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:3];
    assign src_stall = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_bytes <= CFG_MAX_PAYLOAD_RST;
            cfg_reg.supported_major   <= CFG_MAJOR_RST;
            cfg_reg.supported_minor   <= CFG_MINOR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_IDX_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= pwdata[34:0];
                CFG_IDX_MAJOR:       cfg_reg.supported_major   <= pwdata[15:0];
                CFG_IDX_MINOR:       cfg_reg.supported_minor   <= pwdata[15:0];
                default:
                begin
                    // ignore writes beyond the register list
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            CFG_IDX_MAX_PAYLOAD: prdata = {29'd0, cfg_reg.max_payload_bytes};
            CFG_IDX_MAJOR:       prdata = {48'd0, cfg_reg.supported_major};
            CFG_IDX_MINOR:       prdata = {48'd0, cfg_reg.supported_minor};
            default:             prdata = '0;
        endcase
    end

    tsdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .src_valid (src_valid),
        .src_item  (src_item),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    tsdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

FILE: src/tsdc_front.sv
// Stream parser: accepts bytes, checks headers, and emits result items.
`include "trace_stream_deframer_checker_core_assert.svh"

module tsdc_front
    import tsdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      src_valid,
    input  src_item_t src_item,
    input  logic      full,
    output logic      push,
    output res_item_t push_item
);

    typedef enum logic [3:0] {
        PH_FILE_HDR = 4'b0001,
        PH_REC_HDR  = 4'b0010,
        PH_PAYLOAD  = 4'b0100,
        PH_HALT     = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [63:0] seq_reg, seq_next;
    logic [31:0] kind_reg, kind_next;
    logic [31:0] flags_reg, flags_next;
    logic [63:0] size_reg, size_next;
    logic [63:0] expected_reg, expected_next;
    logic [34:0] left_reg, left_next;

    logic        accept;
    logic        clr;
    logic [7:0]  b;
    logic [63:0] seq_g;
    logic [31:0] kind_g;
    logic [31:0] flags_g;
    logic [63:0] size_g;
    logic [34:0] left_dec;

    function automatic res_item_t error_item(input logic [3:0] code);
        res_item_t r;
        r            = '0;
        r.out_type   = OUT_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign accept   = src_valid && !full;
    assign b        = src_item.data_byte;
    assign clr      = (phase_reg == PH_REC_HDR) && (idx_reg == '0);
    assign left_dec = left_reg - 35'd1;

    // Place the incoming byte into its header field lane
    always_comb
    begin
        seq_g   = clr ? '0 : seq_reg;
        kind_g  = clr ? '0 : kind_reg;
        flags_g = clr ? '0 : flags_reg;
        size_g  = clr ? '0 : size_reg;
        priority if (idx_reg < 5'd8)
        begin
            seq_g[{idx_reg[2:0], 3'b000} +: 8] = b;
        end
        else if (idx_reg < 5'd12)
        begin
            kind_g[{idx_reg[1:0], 3'b000} +: 8] = b;
        end
        else if (idx_reg < 5'd16)
        begin
            flags_g[{idx_reg[1:0], 3'b000} +: 8] = b;
        end
        else
        begin
            size_g[{idx_reg[2:0], 3'b000} +: 8] = b;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        seq_next      = seq_reg;
        kind_next     = kind_reg;
        flags_next    = flags_reg;
        size_next     = size_reg;
        expected_next = expected_reg;
        left_next     = left_reg;
        push          = 1'b0;
        push_item     = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_FILE_HDR:
                begin
                    if (src_item.end_of_stream)
                    begin
                        push       = 1'b1;
                        push_item  = error_item(ERR_TRUNCATED);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        seq_next   = seq_g;
                        kind_next  = kind_g;
                        flags_next = flags_g;
                        size_next  = size_g;
                        idx_next   = idx_reg + 5'd1;
                        priority if (idx_reg == MAGIC_LAST_IDX && seq_g != STREAM_MAGIC)
                        begin
                            push       = 1'b1;
                            push_item  = error_item(ERR_MAGIC);
                            phase_next = PH_HALT;
                        end
                        else if (idx_reg == HDR_LAST_IDX)
                        begin
                            idx_next = '0;
                            priority if (kind_g[15:0] != cfg.supported_major)
                            begin
                                push       = 1'b1;
                                push_item  = error_item(ERR_MAJOR);
                                phase_next = PH_HALT;
                            end
                            else if (kind_g[31:16] > cfg.supported_minor)
                            begin
                                push       = 1'b1;
                                push_item  = error_item(ERR_MINOR);
                                phase_next = PH_HALT;
                            end
                            else if (flags_g != ENDIAN_MARK)
                            begin
                                push       = 1'b1;
                                push_item  = error_item(ERR_ENDIAN);
                                phase_next = PH_HALT;
                            end
                            else if (size_g != HEADER_BYTES)
                            begin
                                push       = 1'b1;
                                push_item  = error_item(ERR_HDR_SIZE);
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_REC_HDR;
                            end
                        end
                        else
                        begin
                        end
                    end
                end

                PH_REC_HDR:
                begin
                    if (src_item.end_of_stream)
                    begin
                        // clean end only at a record boundary
                        phase_next = PH_HALT;
                        if (idx_reg != '0)
                        begin
                            push      = 1'b1;
                            push_item = error_item(ERR_TRUNCATED);
                        end
                    end
                    else
                    begin
                        seq_next   = seq_g;
                        kind_next  = kind_g;
                        flags_next = flags_g;
                        size_next  = size_g;
                        if (idx_reg != HDR_LAST_IDX)
                        begin
                            idx_next = idx_reg + 5'd1;
                        end
                        else
                        begin
                            idx_next = '0;
                            push     = 1'b1;
                            priority if (seq_g != expected_reg)
                            begin
                                push_item  = error_item(ERR_SEQUENCE);
                                phase_next = PH_HALT;
                            end
                            else if (kind_g == '0)
                            begin
                                push_item  = error_item(ERR_ZERO_KIND);
                                phase_next = PH_HALT;
                            end
                            else if (size_g > {29'd0, cfg.max_payload_bytes})
                            begin
                                push_item  = error_item(ERR_SIZE);
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                expected_next          = expected_reg + 64'd1;
                                left_next              = size_g[34:0];
                                phase_next             = (size_g[34:0] != '0) ?
                                                         PH_PAYLOAD : PH_REC_HDR;
                                push_item.out_type     = OUT_REC_HDR;
                                push_item.rec_sequence = seq_g;
                                push_item.rec_kind     = kind_g;
                                push_item.rec_flags    = flags_g;
                                push_item.rec_size     = size_g[34:0];
                                push_item.last         = (size_g[34:0] == '0);
                            end
                        end
                    end
                end

                PH_PAYLOAD:
                begin
                    push = 1'b1;
                    if (src_item.end_of_stream)
                    begin
                        push_item  = error_item(ERR_TRUNCATED);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        left_next               = left_dec;
                        phase_next              = (left_dec == '0) ? PH_REC_HDR : PH_PAYLOAD;
                        push_item.out_type      = OUT_PAYLOAD;
                        push_item.rec_sequence  = seq_reg;
                        push_item.rec_kind      = kind_reg;
                        push_item.rec_flags     = flags_reg;
                        push_item.rec_size      = size_reg[34:0];
                        push_item.payload_value = b;
                        push_item.last          = (left_dec == '0);
                    end
                end

                PH_HALT:
                begin
                    // drop everything until reset
                end

                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FILE_HDR;
            idx_reg      <= '0;
            expected_reg <= 64'd1;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            expected_reg <= expected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg   <= seq_next;
        kind_reg  <= kind_next;
        flags_reg <= flags_next;
        size_reg  <= size_next;
        left_reg  <= left_next;
    end

    `TSDC_ASSERT_NXT(a_halt_sticks, phase_reg == PH_HALT, phase_reg == PH_HALT)
    `TSDC_ASSERT_NXT(a_error_halts, push && push_item.out_type == OUT_ERROR,
                     phase_reg == PH_HALT)
    `TSDC_ASSERT_IMP(a_payload_nonempty, phase_reg == PH_PAYLOAD, left_reg != '0)

endmodule

FILE: src/tsdc_queue.sv
// Result queue between the parser and the output channel.
`include "trace_stream_deframer_checker_core_assert.svh"

module tsdc_queue
    import tsdc_pkg::*;
#(
    parameter int DEPTH = TSDC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_item_t push_item,
    output logic      full,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign res_valid = (count_reg != '0);
    assign res_item  = mem[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `TSDC_ASSERT_IMP(a_no_push_when_full, full, !push)
    `TSDC_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

FILE: bench/trace_stream_deframer_checker_core_tb.sv
// Self-checking bench for the trace stream deframer: one stream, checked result by result.
`timescale 1ns / 100ps

module trace_stream_deframer_checker_core_tb
    import tsdc_pkg::*;
();

    localparam logic [63:0] TRACE_MAGIC = "CRTGBDTR";   // "RTDBGTRC" read little-endian
    localparam logic [31:0] ENDIAN_WORD = 32'h0102_0304;
    localparam logic [63:0] HDR_LEN     = 64'd24;
    localparam int          MAGIC_LAST  = 7;
    localparam int          HDR_LAST    = 23;
    localparam int          REPORT_MAX  = 10;

    typedef enum logic [1:0] {ST_FILE_HDR, ST_REC_HDR, ST_PAYLOAD, ST_DONE} parse_state_t;
    typedef enum int {HF_NONE, HF_MAGIC, HF_MAJOR, HF_MINOR, HF_ENDIAN, HF_HDR_SIZE,
                      HF_CUT} hdr_flaw_t;
    typedef enum int {END_CLEAN, END_BAD_SEQ, END_ZERO_KIND, END_OVERSIZE, END_CUT_HEADER,
                      END_CUT_PAYLOAD} stream_end_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  src_valid = 1'b0;
    logic                  src_stall;
    src_item_t             src_item = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_item_t             res_item;

    trace_stream_deframer_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #10 clk = ~clk;

    src_item_t pending_bytes[$];
    res_item_t expected_results[$];
    res_item_t want_item;
    int        mismatches = 0;

    // Shadow of the block's registers and parser state
    cfg_t         cfg_now = {CFG_MAX_PAYLOAD_RST, CFG_MAJOR_RST, CFG_MINOR_RST};
    parse_state_t p_state = ST_FILE_HDR;
    int           p_idx = 0;
    logic [63:0]  p_seq = '0;
    logic [31:0]  p_kind = '0;
    logic [31:0]  p_flags = '0;
    logic [63:0]  p_size = '0;
    logic [63:0]  p_seq_want = 64'd1;
    logic [34:0]  p_left = '0;
    bit           p_failed = 1'b0;

    logic [63:0]  gen_seq = 64'd1;

    bit src_fire = 1'b0;
    bit res_taken = 1'b0;
    int gap_left = 0;
    bit send_calm = 1'b0;
    int stall_left = 0;
    bit stall_calm = 1'b0;

    task automatic clear_fields();
        p_seq = '0;
        p_kind = '0;
        p_flags = '0;
        p_size = '0;
        p_idx = 0;
    endtask

    task automatic collect_byte(input int i, input logic [7:0] b);
        if (i < 8)
            p_seq[8*i +: 8] = b;
        else if (i < 12)
            p_kind[8*(i-8) +: 8] = b;
        else if (i < 16)
            p_flags[8*(i-12) +: 8] = b;
        else
            p_size[8*(i-16) +: 8] = b;
    endtask

    task automatic report_error(input logic [3:0] code);
        res_item_t r;
        r = '0;
        r.out_type = OUT_ERROR;
        r.error_code = code;
        expected_results.push_back(r);
        p_failed = 1'b1;
    endtask

    task automatic report_record(input logic [1:0] kind, input logic [7:0] value,
                                 input logic last);
        res_item_t r;
        r = '0;
        r.out_type = kind;
        r.rec_sequence = p_seq;
        r.rec_kind = p_kind;
        r.rec_flags = p_flags;
        r.rec_size = p_size[34:0];
        r.payload_value = value;
        r.last = last;
        expected_results.push_back(r);
    endtask

    // Advance the parser shadow by one accepted item and queue what it emits
    task automatic deframe_byte(input src_item_t it);
        int i;
        logic [7:0] b;
        i = p_idx;
        b = it.data_byte;
        if (p_failed || p_state == ST_DONE)
            return;
        case (p_state)
            ST_FILE_HDR:
            begin
                if (it.end_of_stream)
                    report_error(ERR_TRUNCATED);
                else
                begin
                    collect_byte(i, b);
                    if (i == MAGIC_LAST && p_seq != TRACE_MAGIC)
                        report_error(ERR_MAGIC);
                    else if (i == HDR_LAST)
                    begin
                        if (p_kind[15:0] != cfg_now.supported_major)
                            report_error(ERR_MAJOR);
                        else if (p_kind[31:16] > cfg_now.supported_minor)
                            report_error(ERR_MINOR);
                        else if (p_flags != ENDIAN_WORD)
                            report_error(ERR_ENDIAN);
                        else if (p_size != HDR_LEN)
                            report_error(ERR_HDR_SIZE);
                        else
                        begin
                            clear_fields();
                            p_state = ST_REC_HDR;
                        end
                    end
                    else
                        p_idx = i + 1;
                end
            end
            ST_REC_HDR:
            begin
                if (it.end_of_stream)
                begin
                    if (i == 0)
                        p_state = ST_DONE;
                    else
                        report_error(ERR_TRUNCATED);
                end
                else
                begin
                    if (i == 0)
                        clear_fields();
                    collect_byte(i, b);
                    if (i != HDR_LAST)
                        p_idx = i + 1;
                    else
                    begin
                        p_idx = 0;
                        if (p_seq != p_seq_want)
                            report_error(ERR_SEQUENCE);
                        else if (p_kind == '0)
                            report_error(ERR_ZERO_KIND);
                        else if (p_size > 64'(cfg_now.max_payload_bytes))
                            report_error(ERR_SIZE);
                        else
                        begin
                            p_seq_want = p_seq_want + 64'd1;
                            p_left = p_size[34:0];
                            if (p_left != '0)
                                p_state = ST_PAYLOAD;
                            report_record(OUT_REC_HDR, 8'h00, p_left == '0);
                        end
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (it.end_of_stream)
                    report_error(ERR_TRUNCATED);
                else
                begin
                    p_left = p_left - 35'd1;
                    if (p_left == '0)
                        p_state = ST_REC_HDR;
                    report_record(OUT_PAYLOAD, b, p_left == '0);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Source side: predict on acceptance, present the next item at the falling edge
    always @(posedge clk)
    begin
        src_fire = rst_n && src_valid && !src_stall;
        if (src_fire)
            deframe_byte(src_item);
    end

    always @(negedge clk)
    begin
        if (src_fire)
        begin
            if ($urandom_range(0, 99) == 0)
                send_calm = !send_calm;
            gap_left = send_calm ? 0 : $urandom_range(0, 15);
        end
        if (!src_valid || src_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                src_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                src_item <= pending_bytes.pop_front();
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // Result side: compare each taken item with the oldest expectation
    always @(posedge clk)
    begin
        res_taken = rst_n && res_valid && !res_stall;
        if (res_taken)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: type %0d error %0d seq %h",
                             res_item.out_type, res_item.error_code, res_item.rec_sequence);
            end
            else
            begin
                want_item = expected_results.pop_front();
                if (res_item.out_type !== want_item.out_type
                    || res_item.rec_sequence !== want_item.rec_sequence
                    || res_item.rec_kind !== want_item.rec_kind
                    || res_item.rec_flags !== want_item.rec_flags
                    || res_item.rec_size !== want_item.rec_size
                    || res_item.payload_value !== want_item.payload_value
                    || res_item.last !== want_item.last
                    || res_item.error_code !== want_item.error_code)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $write("mismatch (expected/actual): type %0d/%0d seq %h/%h",
                               want_item.out_type, res_item.out_type,
                               want_item.rec_sequence, res_item.rec_sequence);
                        $write(" kind %h/%h flags %h/%h size %h/%h",
                               want_item.rec_kind, res_item.rec_kind,
                               want_item.rec_flags, res_item.rec_flags,
                               want_item.rec_size, res_item.rec_size);
                        $display(" byte %h/%h last %b/%b error %0d/%0d",
                                 want_item.payload_value, res_item.payload_value,
                                 want_item.last, res_item.last,
                                 want_item.error_code, res_item.error_code);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (res_taken)
        begin
            if ($urandom_range(0, 99) == 0)
                stall_calm = !stall_calm;
            stall_left = stall_calm ? 0 : $urandom_range(0, 15);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        case (idx)
            CFG_IDX_MAX_PAYLOAD: cfg_now.max_payload_bytes = value[34:0];
            CFG_IDX_MAJOR:       cfg_now.supported_major = value[15:0];
            CFG_IDX_MINOR:       cfg_now.supported_minor = value[15:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_version();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        src_item_t it;
        it.data_byte = b;
        it.end_of_stream = 1'b0;
        pending_bytes.push_back(it);
    endtask

    task automatic put_end();
        src_item_t it;
        it.data_byte = 8'($urandom);
        it.end_of_stream = 1'b1;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_rec_header(input logic [63:0] seq, input logic [31:0] kind,
                                    input logic [31:0] flags, input logic [63:0] size,
                                    input int nbytes);
        logic [191:0] v;
        v = {size, flags, kind, seq};
        for (int i = 0; i < nbytes; i++)
            put_byte(v[8*i +: 8]);
    endtask

    task automatic queue_record(input logic [31:0] kind, input logic [31:0] flags,
                                input int size);
        queue_rec_header(gen_seq, kind, flags, 64'(size), 24);
        gen_seq = gen_seq + 64'd1;
        repeat (size)
            put_byte(8'($urandom));
    endtask

    task automatic queue_random_record();
        logic [31:0] kind;
        logic [31:0] flags;
        int lim;
        kind = $urandom;
        flags = $urandom;
        case ($urandom_range(0, 9))
            0: kind = 32'h1;
            1: kind = 32'hFFFF_FFFF;
            2: flags = 32'h0;
            3: flags = 32'hFFFF_FFFF;
            default:
            begin
            end
        endcase
        if (kind == '0)
            kind = 32'h1;
        lim = ($urandom_range(0, 15) == 0) ? 64 : 12;
        if (cfg_now.max_payload_bytes < 35'(lim))
            lim = int'(cfg_now.max_payload_bytes);
        queue_record(kind, flags, $urandom_range(0, lim));
    endtask

    // Good header most of the time; now and then one broken field, maybe with later ones, or a cut header
    task automatic queue_file_header();
        logic [15:0] major;
        logic [15:0] minor;
        logic [31:0] mark;
        logic [63:0] magic;
        logic [63:0] hsize;
        logic [191:0] v;
        hdr_flaw_t flaw;
        int nbytes;
        major = cfg_now.supported_major;
        minor = $urandom_range(0, 1) ? cfg_now.supported_minor
                                     : 16'($urandom_range(0, cfg_now.supported_minor));
        magic = TRACE_MAGIC;
        mark = ENDIAN_WORD;
        hsize = HDR_LEN;
        flaw = ($urandom_range(0, 7) == 0) ? hdr_flaw_t'($urandom_range(1, 6)) : HF_NONE;
        if (flaw == HF_MAGIC)
            magic[$urandom_range(0, 63)] ^= 1'b1;
        if (flaw == HF_MAJOR)
            major[$urandom_range(0, 15)] ^= 1'b1;
        if (flaw == HF_MINOR || (flaw == HF_MAJOR && $urandom_range(0, 1)))
            minor = cfg_now.supported_minor + 16'd1;
        if (flaw == HF_ENDIAN || (flaw inside {HF_MAJOR, HF_MINOR} && $urandom_range(0, 1)))
            mark[$urandom_range(0, 31)] ^= 1'b1;
        if (flaw == HF_HDR_SIZE
            || (flaw inside {HF_MAJOR, HF_MINOR, HF_ENDIAN} && $urandom_range(0, 1)))
            hsize[$urandom_range(0, 63)] ^= 1'b1;
        v = {hsize, mark, minor, major, magic};
        nbytes = (flaw == HF_CUT) ? $urandom_range(0, 23) : 24;
        for (int i = 0; i < nbytes; i++)
            put_byte(v[8*i +: 8]);
        if (flaw == HF_CUT)
            put_end();
    endtask

    // Hold until the sender is drained and every expected result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || src_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [34:0] max_bytes;
        logic [63:0] size;
        stream_end_t end_kind;
        src_item_t noise;
        int cut;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_IDX_MAJOR, {32'($urandom), 16'($urandom), pick_version()});
        write_reg(CFG_IDX_MINOR, {32'($urandom), 16'($urandom), pick_version()});
        write_reg(CFG_IDX_MAX_PAYLOAD, {29'($urandom), 35'd3});

        // Directed: empty record, extreme kinds and flags, payload of exactly the limit
        queue_file_header();
        queue_record(32'hFFFF_FFFF, 32'h0000_0000, 0);
        queue_record(32'h0000_0001, 32'hFFFF_FFFF, 1);
        queue_record(32'($urandom) | 32'h1, 32'($urandom), 3);
        queue_record(32'($urandom) | 32'h1, 32'($urandom), 2);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: max_bytes = 35'd0;
                1: max_bytes = 35'd1;
                2: max_bytes = 35'h7_FFFF_FFFF;
                3: max_bytes = 35'($urandom_range(2, 40));
                4: max_bytes = CFG_MAX_PAYLOAD_RST;
                default: max_bytes = 35'($urandom_range(8, 64));
            endcase
            write_reg(CFG_IDX_MAX_PAYLOAD, {29'($urandom), max_bytes});
            write_reg(CFG_IDX_MAJOR, {48'($urandom), pick_version()});
            write_reg(CFG_IDX_MINOR, {48'($urandom), pick_version()});
            while (pending_bytes.size() < 230)
                queue_random_record();
            wait_idle();
        end

        // Close the stream cleanly or with one broken record, then feed ignored noise
        end_kind = stream_end_t'($urandom_range(0, 5));
        size = $urandom_range(0, 1) ? 64'(cfg_now.max_payload_bytes) + 64'($urandom_range(1, 4))
                                    : {32'($urandom), 32'($urandom)} | 64'h8000_0000_0000_0000;
        case (end_kind)
            END_CLEAN:
                put_end();
            END_BAD_SEQ:
                queue_rec_header(gen_seq ^ (64'd1 << $urandom_range(0, 63)),
                                 $urandom_range(0, 1) ? 32'h0 : 32'($urandom),
                                 32'($urandom), $urandom_range(0, 1) ? size : 64'd0, 24);
            END_ZERO_KIND:
                queue_rec_header(gen_seq, 32'h0, 32'($urandom),
                                 $urandom_range(0, 1) ? size : 64'd0, 24);
            END_OVERSIZE:
                queue_rec_header(gen_seq, 32'($urandom) | 32'h1, 32'($urandom), size, 24);
            END_CUT_HEADER:
            begin
                queue_rec_header(gen_seq, 32'($urandom) | 32'h1, 32'($urandom), 64'd0,
                                 $urandom_range(1, 23));
                put_end();
            end
            default:
            begin
                cut = $urandom_range(1, 8);
                queue_rec_header(gen_seq, 32'($urandom) | 32'h1, 32'($urandom), 64'(cut), 24);
                repeat ($urandom_range(0, cut - 1))
                    put_byte(8'($urandom));
                put_end();
            end
        endcase
        repeat (20)
        begin
            noise.data_byte = 8'($urandom);
            noise.end_of_stream = ($urandom_range(0, 3) == 0);
            pending_bytes.push_back(noise);
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/tsdc_pkg.sv
src/tsdc_front.sv
src/tsdc_queue.sv
src/trace_stream_deframer_checker_core.sv
bench/trace_stream_deframer_checker_core_tb.sv
